// ===== hdl/wsdf_pkg.sv =====
package wsdf_pkg;

  // header length codes
  localparam logic [6:0] LEN7_MAX   = 7'd125;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;

  // header bytes still due after the length code or the mask flag
  localparam logic [3:0] HC_EXT16 = 4'd2;
  localparam logic [3:0] HC_EXT64 = 4'd8;
  localparam logic [3:0] HC_KEY   = 4'd4;

  // command queue between parser and output stage
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0]  stream_byte;
    logic [7:0]  key_byte;
    logic        empty_frame;
    logic        fin_bit;
    logic [2:0]  reserved_bits;
    logic [3:0]  op_code;
    logic        was_masked;
    logic [63:0] frame_length;
    logic        last_byte;
  } cmd_t;

endpackage

// ===== hdl/wsdf_front.sv =====
module wsdf_front
  import wsdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_take,
  input  logic [7:0] in_byte,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  hcount, hcount_next;
  logic        fin, fin_next;
  logic [2:0]  rsv, rsv_next;
  logic [3:0]  opcode, opcode_next;
  logic        mflag, mflag_next;
  logic [63:0] len, len_next;
  logic [31:0] key, key_next;
  logic [63:0] left, left_next;
  logic [1:0]  kidx, kidx_next;

  logic        do_len, do_hdr;
  logic [7:0]  key_byte;

  always_comb begin
    case (kidx)
      2'd0:    key_byte = key[31:24];
      2'd1:    key_byte = key[23:16];
      2'd2:    key_byte = key[15:8];
      default: key_byte = key[7:0];
    endcase
  end

  always_comb begin
    phase_next  = phase;
    hcount_next = hcount;
    fin_next    = fin;
    rsv_next    = rsv;
    opcode_next = opcode;
    mflag_next  = mflag;
    len_next    = len;
    key_next    = key;
    left_next   = left;
    kidx_next   = kidx;
    do_len      = 1'b0;
    do_hdr      = 1'b0;
    cmd_valid   = 1'b0;
    cmd.stream_byte = in_byte;
    cmd.key_byte    = 8'd0;
    cmd.empty_frame = 1'b0;
    cmd.last_byte   = 1'b0;

    if (in_take) begin
      case (phase)
        PH_HDR1: begin
          mflag_next = in_byte[7];
          if (in_byte[6:0] <= LEN7_MAX) begin
            len_next = {57'd0, in_byte[6:0]};
            do_len   = 1'b1;
          end else begin
            len_next    = 64'd0;
            hcount_next = (in_byte[6:0] == LEN7_EXT16) ? HC_EXT16 : HC_EXT64;
            phase_next  = PH_EXTLEN;
          end
        end
        PH_EXTLEN: begin
          len_next    = {len[55:0], in_byte};
          hcount_next = hcount - 4'd1;
          if (hcount_next == 4'd0) do_len = 1'b1;
        end
        PH_MASK: begin
          key_next    = {key[23:0], in_byte};
          hcount_next = hcount - 4'd1;
          if (hcount_next == 4'd0) do_hdr = 1'b1;
        end
        PH_PAYLOAD: begin
          kidx_next    = kidx + 2'd1;
          left_next    = left - 64'd1;
          cmd_valid    = 1'b1;
          cmd.key_byte = key_byte;
          if (left_next == 64'd0) begin
            cmd.last_byte = 1'b1;
            phase_next    = PH_HDR0;
          end
        end
        default: begin
          // unused phase codes behave as header byte zero
          fin_next    = in_byte[7];
          rsv_next    = in_byte[6:4];
          opcode_next = in_byte[3:0];
          phase_next  = PH_HDR1;
        end
      endcase

      if (do_len) begin
        key_next = 32'd0;
        if (mflag_next) begin
          hcount_next = HC_KEY;
          phase_next  = PH_MASK;
        end else begin
          do_hdr = 1'b1;
        end
      end

      if (do_hdr) begin
        kidx_next = 2'd0;
        if (len_next == 64'd0) begin
          left_next       = 64'd0;
          phase_next      = PH_HDR0;
          cmd_valid       = 1'b1;
          cmd.empty_frame = 1'b1;
          cmd.last_byte   = 1'b1;
        end else begin
          left_next  = len_next;
          phase_next = PH_PAYLOAD;
        end
      end
    end

    cmd.fin_bit       = fin_next;
    cmd.reserved_bits = rsv_next;
    cmd.op_code       = opcode_next;
    cmd.was_masked    = mflag_next;
    cmd.frame_length  = len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HDR0;
      hcount <= 4'd0;
      fin    <= 1'b0;
      rsv    <= 3'd0;
      opcode <= 4'd0;
      mflag  <= 1'b0;
      len    <= 64'd0;
      key    <= 32'd0;
      left   <= 64'd0;
      kidx   <= 2'd0;
    end else begin
      phase  <= phase_next;
      hcount <= hcount_next;
      fin    <= fin_next;
      rsv    <= rsv_next;
      opcode <= opcode_next;
      mflag  <= mflag_next;
      len    <= len_next;
      key    <= key_next;
      left   <= left_next;
      kidx   <= kidx_next;
    end
  end

endmodule

// ===== hdl/wsdf_queue.sv =====
module wsdf_queue
  import wsdf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic q_full,
  output logic q_valid,
  input  logic rd_en,
  output cmd_t rd_data
);

  cmd_t             entries [QDEPTH];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QAW:0]     count;

  logic do_wr, do_rd;

  assign q_full  = (count == (QAW+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/wsdf_back.sv =====
module wsdf_back
  import wsdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_data,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  data_byte,
  output logic        empty_frame,
  output logic        fin_bit,
  output logic [2:0]  reserved_bits,
  output logic [3:0]  op_code,
  output logic        was_masked,
  output logic [63:0] frame_length,
  output logic        last_byte
);

  logic out_valid;

  assign empty = !out_valid;
  // refill the output register when it is free or being taken this cycle
  assign q_pop = q_valid && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_byte     <= q_data.empty_frame ? 8'd0 : (q_data.stream_byte ^ q_data.key_byte);
      empty_frame   <= q_data.empty_frame;
      fin_bit       <= q_data.fin_bit;
      reserved_bits <= q_data.reserved_bits;
      op_code       <= q_data.op_code;
      was_masked    <= q_data.was_masked;
      frame_length  <= q_data.frame_length;
      last_byte     <= q_data.last_byte;
    end
  end

endmodule

// ===== hdl/websocket_frame_deframer.sv =====
// WebSocket frame deframer: push one stream byte per cycle; header, extended length
// and mask key bytes produce nothing, each payload byte comes out unmasked with its
// frame's fin, reserved bits, opcode, mask flag and length, and a frame of zero length
// gives one result marked empty_frame. A byte is taken every cycle that full is low; a
// four-entry command queue sits between the header parser and the output register, so
// full rises only after five results wait unread (four in the queue, one on the output
// ports), and each result is written into the queue and then loaded into the output
// register, which drives the output ports.
module websocket_frame_deframer
  import wsdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  data_byte,
  output logic        empty_frame,
  output logic        fin_bit,
  output logic [2:0]  reserved_bits,
  output logic [3:0]  op_code,
  output logic        was_masked,
  output logic [63:0] frame_length,
  output logic        last_byte
);

  logic in_take;
  logic cmd_valid;
  cmd_t cmd;
  logic q_valid, q_pop;
  cmd_t q_data;

  assign in_take = push && !full;

  wsdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .in_byte   (in_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  wsdf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .q_full  (full),
    .q_valid (q_valid),
    .rd_en   (q_pop),
    .rd_data (q_data)
  );

  wsdf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .data_byte     (data_byte),
    .empty_frame   (empty_frame),
    .fin_bit       (fin_bit),
    .reserved_bits (reserved_bits),
    .op_code       (op_code),
    .was_masked    (was_masked),
    .frame_length  (frame_length),
    .last_byte     (last_byte)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (q_valid && empty) |=> !empty)
    else $error("queued item not moved to output");

  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    (!empty && empty_frame) |-> (data_byte == 8'd0 && last_byte && frame_length == 64'd0))
    else $error("empty frame item malformed");

  a_full_has_items: assert property (@(posedge clk) disable iff (rst)
    full |-> (q_valid && !empty))
    else $error("full without waiting items");

endmodule
